### sv/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational arithmetic unit
// Operation and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int IN_W   = 16;
  localparam int OP_W   = 2;
  localparam int NUM_W  = 33;
  localparam int DEN_W  = 31;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_UNDEF    = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    MS_NUM   = 2'd0,
    MS_DEN   = 2'd1,
    MS_CROSS = 2'd2
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_SIGN,
    ST_GCD,
    ST_SCALE,
    ST_DIV_N,
    ST_SWAP,
    ST_DIV_D,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sign_init;
    logic     gcd_step;
    logic     scale;
    logic     div_step;
    logic     div_swap;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic addsub;
    logic zz;
    logic gcd_done;
  } sts_t;

endpackage

### sv/rar_datapath.sv
// ----------------------------------------------------------------------------
// rar_datapath: operand registers, shared multiplier, binary GCD and divider
// Carries out the commands of the controller and reports loop conditions.
// ----------------------------------------------------------------------------
module rar_datapath #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                              clk,
  input  rar_pkg::cmd_t                     cmd,
  output rar_pkg::sts_t                     sts,
  input  logic [rar_pkg::OP_W-1:0]          in_req_type,
  input  logic signed [rar_pkg::IN_W-1:0]   in_a_num,
  input  logic signed [rar_pkg::IN_W-1:0]   in_a_den,
  input  logic signed [rar_pkg::IN_W-1:0]   in_b_num,
  input  logic signed [rar_pkg::IN_W-1:0]   in_b_den,
  output logic signed [rar_pkg::NUM_W-1:0]  out_res_num,
  output logic [rar_pkg::DEN_W-1:0]         out_res_den,
  output logic [rar_pkg::STAT_W-1:0]        out_status
);

  localparam int EW = (OPERAND_WIDTH <= rar_pkg::IN_W) ? OPERAND_WIDTH : rar_pkg::IN_W + 1;
  localparam int MW = 2 * EW;
  localparam int NW = MW + 1;
  localparam int KW = $clog2(MW);
  localparam int XN = (NW > rar_pkg::NUM_W) ? NW : rar_pkg::NUM_W;
  localparam int XD = (MW > rar_pkg::DEN_W) ? MW : rar_pkg::DEN_W;

  logic signed [EW-1:0] an_x, ad_x, bn_x, bd_x;

  if (OPERAND_WIDTH <= rar_pkg::IN_W) begin : g_narrow
    assign an_x = in_a_num[EW-1:0];
    assign ad_x = in_a_den[EW-1:0];
    assign bn_x = in_b_num[EW-1:0];
    assign bd_x = in_b_den[EW-1:0];
  end else begin : g_wide
    assign an_x = {1'b0, in_a_num};
    assign ad_x = {1'b0, in_a_den};
    assign bn_x = {1'b0, in_b_num};
    assign bd_x = {1'b0, in_b_den};
  end

  rar_pkg::op_t         op_r;
  logic signed [EW-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [NW-1:0] num_r;
  logic signed [MW-1:0] den_r;
  logic [MW-1:0]        nmag_r, dmag_r;
  logic                 neg_r;
  rar_pkg::stat_t       stat_r;
  logic [MW-1:0]        gx_r, gy_r, g_r;
  logic [KW-1:0]        gk_r;
  logic [MW-1:0]        rem_r, dq_r, nq_r;
  logic signed [rar_pkg::NUM_W-1:0] res_num_r;
  logic [rar_pkg::DEN_W-1:0]        res_den_r;
  rar_pkg::stat_t                   res_stat_r;

  logic signed [EW-1:0] mx, my;
  logic signed [MW-1:0] prod;
  logic                 num_neg, den_neg;
  logic [NW-1:0]        num_abs;
  logic [MW-1:0]        den_abs;
  logic [MW:0]          shifted, diff;
  logic                 ge;
  logic signed [MW:0]   sq, nv;
  logic signed [XN-1:0] num_ext;
  logic [XD-1:0]        den_ext;

  always_comb begin
    unique case (cmd.mul_sel)
      rar_pkg::MS_NUM: begin
        mx = an_r;
        my = (op_r == rar_pkg::OP_MUL) ? bn_r : bd_r;
      end
      rar_pkg::MS_DEN: begin
        mx = ad_r;
        my = (op_r == rar_pkg::OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mx = bn_r;
        my = ad_r;
      end
    endcase
  end

  assign prod    = mx * my;
  assign num_neg = num_r[NW-1];
  assign den_neg = den_r[MW-1];
  assign num_abs = num_neg ? NW'(-num_r) : NW'(num_r);
  assign den_abs = den_neg ? MW'(-den_r) : MW'(den_r);

  assign shifted = {rem_r, dq_r[MW-1]};
  assign diff    = shifted - {1'b0, g_r};
  assign ge      = ~diff[MW];

  assign sq      = {1'b0, nq_r};
  assign nv      = neg_r ? -sq : sq;
  assign num_ext = XN'(nv);
  assign den_ext = XD'(dq_r);

  assign sts.addsub   = (op_r == rar_pkg::OP_ADD) || (op_r == rar_pkg::OP_SUB);
  assign sts.zz       = (num_r == '0) && (den_r == '0);
  assign sts.gcd_done = (gx_r == '0) || (gy_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= rar_pkg::op_t'(in_req_type);
      an_r <= an_x;
      ad_r <= ad_x;
      bn_r <= bn_x;
      bd_r <= bd_x;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rar_pkg::MS_NUM: num_r <= NW'(prod);
        rar_pkg::MS_DEN: den_r <= prod;
        default: begin
          if (op_r == rar_pkg::OP_SUB) begin
            num_r <= num_r - NW'(prod);
          end else begin
            num_r <= num_r + NW'(prod);
          end
        end
      endcase
    end
    if (cmd.sign_init) begin
      nmag_r <= num_abs[MW-1:0];
      dmag_r <= den_abs;
      gx_r   <= num_abs[MW-1:0];
      gy_r   <= den_abs;
      gk_r   <= '0;
      nq_r   <= '0;
      dq_r   <= '0;
      if (sts.zz) begin
        neg_r  <= 1'b0;
        stat_r <= rar_pkg::STAT_UNDEF;
      end else begin
        neg_r  <= num_neg ^ den_neg;
        stat_r <= (den_r == '0) ? rar_pkg::STAT_ZERO_DEN : rar_pkg::STAT_OK;
      end
    end
    if (cmd.gcd_step) begin
      case ({gx_r[0], gy_r[0]})
        2'b00: begin
          gx_r <= gx_r >> 1;
          gy_r <= gy_r >> 1;
          gk_r <= gk_r + KW'(1);
        end
        2'b01: gx_r <= gx_r >> 1;
        2'b10: gy_r <= gy_r >> 1;
        default: begin
          if (gx_r >= gy_r) begin
            gx_r <= gx_r - gy_r;
          end else begin
            gy_r <= gy_r - gx_r;
          end
        end
      endcase
    end
    if (cmd.scale) begin
      g_r   <= (gx_r | gy_r) << gk_r;
      dq_r  <= nmag_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? diff[MW-1:0] : shifted[MW-1:0];
      dq_r  <= {dq_r[MW-2:0], ge};
    end
    if (cmd.div_swap) begin
      nq_r  <= dq_r;
      dq_r  <= dmag_r;
      rem_r <= '0;
    end
    if (cmd.out_load) begin
      res_num_r  <= num_ext[rar_pkg::NUM_W-1:0];
      res_den_r  <= den_ext[rar_pkg::DEN_W-1:0];
      res_stat_r <= stat_r;
    end
  end

  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_status  = res_stat_r;

endmodule

### sv/rar_ctrl.sv
// ----------------------------------------------------------------------------
// rar_ctrl: sequencing state machine of the rational arithmetic unit
// Steps the datapath through products, GCD, two divisions and the output beat.
// ----------------------------------------------------------------------------
module rar_ctrl #(
  parameter int MAG_W = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rar_pkg::sts_t sts,
  output rar_pkg::cmd_t cmd
);

  localparam int CW = $clog2(MAG_W);

  rar_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            div_last;

  assign div_last  = (cnt_r == CW'(MAG_W - 1));
  assign in_ready  = (state_r == rar_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rar_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      rar_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = rar_pkg::ST_MUL_A;
        end
      end
      rar_pkg::ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rar_pkg::MS_NUM;
        state_nxt   = rar_pkg::ST_MUL_B;
      end
      rar_pkg::ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rar_pkg::MS_DEN;
        state_nxt   = sts.addsub ? rar_pkg::ST_MUL_C : rar_pkg::ST_SIGN;
      end
      rar_pkg::ST_MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rar_pkg::MS_CROSS;
        state_nxt   = rar_pkg::ST_SIGN;
      end
      rar_pkg::ST_SIGN: begin
        cmd.sign_init = 1'b1;
        state_nxt     = sts.zz ? rar_pkg::ST_DONE : rar_pkg::ST_GCD;
      end
      rar_pkg::ST_GCD: begin
        if (sts.gcd_done) begin
          state_nxt = rar_pkg::ST_SCALE;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      rar_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        cnt_nxt   = '0;
        state_nxt = rar_pkg::ST_DIV_N;
      end
      rar_pkg::ST_DIV_N: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (div_last) begin
          state_nxt = rar_pkg::ST_SWAP;
        end
      end
      rar_pkg::ST_SWAP: begin
        cmd.div_swap = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = rar_pkg::ST_DIV_D;
      end
      rar_pkg::ST_DIV_D: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (div_last) begin
          state_nxt = rar_pkg::ST_DONE;
        end
      end
      rar_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rar_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == rar_pkg::ST_MUL_A)
    else $error("accepted beat did not start the product sequence");

  a_zz_skips: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rar_pkg::ST_SIGN && sts.zz |=> state_r == rar_pkg::ST_DONE)
    else $error("zero over zero did not bypass the reduction");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rar_pkg::ST_DIV_N && div_last |=> state_r == rar_pkg::ST_SWAP)
    else $error("numerator division did not end after its last step");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rar_pkg::ST_DONE && (!out_valid_r || out_ready)
    |=> out_valid_r && state_r == rar_pkg::ST_IDLE)
    else $error("finished result not moved to the output register");

endmodule

### sv/rational_arith_reduce_top.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce_top: exact add, subtract, multiply, divide of fractions
// Forms the cross products, reduces by the GCD and makes the denominator
// non-negative; one result beat per input beat.
// ----------------------------------------------------------------------------
// One item at a time: an item runs its products through one shared
// multiplier, then a sign step, a binary GCD of up to about 4*M steps (each
// subtraction is followed by at least one halving, so the steps run to
// about twice the bits of both magnitudes) plus a check that sees it finish,
// a scale step, a swap step and two restoring divisions of M steps each,
// and the load of the output register, where M is twice the internal operand
// width (the operand width up to 16, else 17), so 32 at the default; the GCD
// loop and the divider dominate in the worst case. Zero over zero skips the
// reduction. The result waits in an output register, so a new item is taken
// while the previous result is still held; the load of the next result
// waits until that one is accepted. Status 1 marks a zero denominator
// (numerator +1 or -1, denominator 0); status 2 marks zero over zero with
// a zero result.
module rational_arith_reduce_top #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rar_pkg::OP_W-1:0]          in_req_type,
  input  logic signed [rar_pkg::IN_W-1:0]   in_a_num,
  input  logic signed [rar_pkg::IN_W-1:0]   in_a_den,
  input  logic signed [rar_pkg::IN_W-1:0]   in_b_num,
  input  logic signed [rar_pkg::IN_W-1:0]   in_b_den,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rar_pkg::NUM_W-1:0]  out_res_num,
  output logic [rar_pkg::DEN_W-1:0]         out_res_den,
  output logic [rar_pkg::STAT_W-1:0]        out_status
);

  localparam int EW = (OPERAND_WIDTH <= rar_pkg::IN_W) ? OPERAND_WIDTH : rar_pkg::IN_W + 1;
  localparam int MW = 2 * EW;

  rar_pkg::cmd_t cmd;
  rar_pkg::sts_t sts;

  rar_ctrl #(
    .MAG_W (MW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rar_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .in_req_type (in_req_type),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

endmodule
